@@ hw/rtl/tplme_pkg.sv @@
// Shared constants, command and status types and helper functions of the path-maximum engine.
`timescale 1ns / 1ps

package tplme_pkg;

  localparam int NODES     = 1024;
  localparam int LEVELS    = 10;
  localparam int IN_NODE_W = 10;
  localparam int WEIGHT_W  = 31;
  localparam int COST_W    = 41;
  localparam int RESULT_W  = 42;
  localparam int NODE_W    = $clog2(NODES);
  localparam int DEP_W     = $clog2(NODES + 1);
  localparam int LVL_W     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int LVC_W     = $clog2(LEVELS + 1);
  localparam int TAB_DEPTH = LEVELS * NODES;
  localparam int TAB_AW    = $clog2(TAB_DEPTH);

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_LD_DEP,
    OP_LD_ISS,
    OP_LD_WR,
    OP_Q_DB,
    OP_Q_DC,
    OP_CL_ISS,
    OP_CL_W,
    OP_CL_SKIP,
    OP_LIFT_INIT,
    OP_LA,
    OP_LB,
    OP_LC,
    OP_FA,
    OP_FB,
    OP_FC,
    OP_FIN
  } op_e;

  typedef struct packed {
    op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic in_func;
    logic in_a_zero;
    logic in_self;
    logic lvl_last;
    logic lvl_zero;
    logic cl_done;
    logic delta_bit;
    logic uv_eq;
    logic out_free;
  } dp_status_t;

  // Node numbers at or above the table size fold onto the empty node.
  function automatic logic [NODE_W-1:0] node_of(input logic [IN_NODE_W-1:0] v);
    logic [NODE_W-1:0] r;
    r = '0;
    if (32'(v) < NODES) begin
      r = NODE_W'(v);
    end
    return r;
  endfunction

  function automatic logic [WEIGHT_W-1:0] wmax(input logic [WEIGHT_W-1:0] a,
                                               input logic [WEIGHT_W-1:0] b);
    return (a > b) ? a : b;
  endfunction

  function automatic logic [TAB_AW-1:0] tab_addr(input logic [LVL_W-1:0] lvl,
                                                 input logic [NODE_W-1:0] node);
    return TAB_AW'({lvl, node});
  endfunction

endpackage

@@ hw/rtl/tplme_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module tplme_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/tplme_ctrl.sv @@
// Controller state machine sequencing loads and queries through the datapath.
`timescale 1ns / 1ps

module tplme_ctrl
  import tplme_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_LD_DEP = 4'd1;
  localparam logic [3:0] S_LD_ISS = 4'd2;
  localparam logic [3:0] S_LD_WR  = 4'd3;
  localparam logic [3:0] S_Q_DB   = 4'd4;
  localparam logic [3:0] S_Q_DC   = 4'd5;
  localparam logic [3:0] S_CL     = 4'd6;
  localparam logic [3:0] S_CL_W   = 4'd7;
  localparam logic [3:0] S_CHK    = 4'd8;
  localparam logic [3:0] S_LA     = 4'd9;
  localparam logic [3:0] S_LB     = 4'd10;
  localparam logic [3:0] S_LC     = 4'd11;
  localparam logic [3:0] S_FA     = 4'd12;
  localparam logic [3:0] S_FB     = 4'd13;
  localparam logic [3:0] S_FC     = 4'd14;
  localparam logic [3:0] S_FIN    = 4'd15;

  logic [3:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d    = state_q;
    cmd_o.op   = OP_NONE;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_ACCEPT;
          if (status_i.in_func == FUNC_LOAD) begin
            state_d = status_i.in_a_zero ? S_IDLE : S_LD_DEP;
          end else begin
            state_d = status_i.in_self ? S_FIN : S_Q_DB;
          end
        end
      end
      S_LD_DEP: begin
        cmd_o.op = OP_LD_DEP;
        state_d  = (LEVELS > 1) ? S_LD_ISS : S_IDLE;
      end
      S_LD_ISS: begin
        cmd_o.op = OP_LD_ISS;
        state_d  = S_LD_WR;
      end
      S_LD_WR: begin
        cmd_o.op = OP_LD_WR;
        state_d  = status_i.lvl_last ? S_IDLE : S_LD_ISS;
      end
      S_Q_DB: begin
        cmd_o.op = OP_Q_DB;
        state_d  = S_Q_DC;
      end
      S_Q_DC: begin
        cmd_o.op = OP_Q_DC;
        state_d  = S_CL;
      end
      S_CL: begin
        if (status_i.cl_done) begin
          state_d = S_CHK;
        end else if (status_i.delta_bit) begin
          cmd_o.op = OP_CL_ISS;
          state_d  = S_CL_W;
        end else begin
          cmd_o.op = OP_CL_SKIP;
        end
      end
      S_CL_W: begin
        cmd_o.op = OP_CL_W;
        state_d  = S_CL;
      end
      S_CHK: begin
        cmd_o.op = OP_LIFT_INIT;
        state_d  = status_i.uv_eq ? S_FIN : S_LA;
      end
      S_LA: begin
        cmd_o.op = OP_LA;
        state_d  = S_LB;
      end
      S_LB: begin
        cmd_o.op = OP_LB;
        state_d  = S_LC;
      end
      S_LC: begin
        cmd_o.op = OP_LC;
        state_d  = status_i.lvl_zero ? S_FA : S_LA;
      end
      S_FA: begin
        cmd_o.op = OP_FA;
        state_d  = S_FB;
      end
      S_FB: begin
        cmd_o.op = OP_FB;
        state_d  = S_FC;
      end
      S_FC: begin
        cmd_o.op = OP_FC;
        state_d  = S_FIN;
      end
      S_FIN: begin
        if (status_i.out_free) begin
          cmd_o.op = OP_FIN;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ hw/rtl/tplme_dp.sv @@
// Datapath: lifting tables, working registers, cost register and result register.
`timescale 1ns / 1ps

module tplme_dp
  import tplme_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dp_cmd_t               cmd_i,
  output dp_status_t            status_o,
  input  logic                  cfg_we_i,
  input  logic [COST_W-1:0]     cfg_wdata_i,
  input  logic                  func_i,
  input  logic [IN_NODE_W-1:0]  node_a_i,
  input  logic [IN_NODE_W-1:0]  node_b_i,
  input  logic [WEIGHT_W-1:0]   weight_i,
  input  logic                  in_tree_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [WEIGHT_W-1:0]   path_max_o,
  output logic [RESULT_W-1:0]   replacement_cost_o
);

  logic [COST_W-1:0]   cost_q;
  logic                out_valid_q;
  logic [WEIGHT_W-1:0] pm_q;
  logic [RESULT_W-1:0] res_q;

  logic [NODE_W-1:0]   u_q, v_q, anc_q, au_q;
  logic [WEIGHT_W-1:0] w_q, best_q, mx_q, mu_q;
  logic                it_q;
  logic [RESULT_W-1:0] sum_q;
  logic [LVC_W-1:0]    lvl_q;
  logic [DEP_W-1:0]    d_q, da_q;
  logic [LEVELS-1:0]   delta_q;
  logic                dzero_q, tzero_q;

  logic [LVL_W-1:0]    lvl_idx, lvl_m1;
  logic [LVC_W-1:0]    lvl_dec;
  logic [NODE_W-1:0]   dep_rnode, tab_rnode;
  logic [LVL_W-1:0]    tab_rlvl;
  logic [DEP_W-1:0]    dep_raw, dep_rd, d_new;
  logic [DEP_W:0]      dep_inc;
  logic [NODE_W-1:0]   anc_raw, anc_rd, anc_new, tab_wanc;
  logic [WEIGHT_W-1:0] max_raw, max_rd, max_new, tab_wmax;
  logic                dep_we, tab_we, ld_on;
  logic [LVL_W-1:0]    tab_wlvl;
  logic [RESULT_W-1:0] best_ext, res_new;

  assign lvl_idx = lvl_q[LVL_W-1:0];
  assign lvl_dec = lvl_q - LVC_W'(1);
  assign lvl_m1  = lvl_dec[LVL_W-1:0];

  // The empty node is never written, so its reads are forced to zero here.
  assign dep_rd = dzero_q ? '0 : dep_raw;
  assign anc_rd = tzero_q ? '0 : anc_raw;
  assign max_rd = tzero_q ? '0 : max_raw;

  assign dep_inc = {1'b0, dep_rd} + (DEP_W + 1)'(1);
  assign d_new   = (dep_inc > (DEP_W + 1)'(NODES)) ? DEP_W'(NODES) : dep_inc[DEP_W-1:0];
  assign ld_on   = ((d_q >> lvl_q) != '0);
  assign anc_new = ld_on ? anc_rd : '0;
  assign max_new = ld_on ? wmax(mx_q, max_rd) : '0;

  always_comb begin
    dep_rnode = v_q;
    tab_rnode = u_q;
    tab_rlvl  = lvl_idx;
    case (cmd_i.op)
      OP_ACCEPT: dep_rnode = (func_i == FUNC_QUERY) ? node_of(node_a_i) : node_of(node_b_i);
      OP_LD_ISS: begin
        tab_rnode = anc_q;
        tab_rlvl  = lvl_m1;
      end
      OP_LB:     tab_rnode = v_q;
      OP_FA:     tab_rlvl  = '0;
      OP_FB: begin
        tab_rnode = v_q;
        tab_rlvl  = '0;
      end
      default: ;
    endcase
  end

  always_comb begin
    dep_we   = (cmd_i.op == OP_LD_DEP);
    tab_we   = 1'b0;
    tab_wlvl = lvl_idx;
    tab_wanc = anc_new;
    tab_wmax = max_new;
    case (cmd_i.op)
      OP_LD_DEP: begin
        tab_we   = 1'b1;
        tab_wlvl = '0;
        tab_wanc = v_q;
        tab_wmax = w_q;
      end
      OP_LD_WR: tab_we = 1'b1;
      default: ;
    endcase
  end

  tplme_ram #(.WIDTH(DEP_W), .DEPTH(NODES)) u_depth_ram (
    .clk_i  (clk_i),
    .we_i   (dep_we),
    .waddr_i(u_q),
    .wdata_i(d_new),
    .raddr_i(dep_rnode),
    .rdata_o(dep_raw)
  );

  tplme_ram #(.WIDTH(NODE_W), .DEPTH(TAB_DEPTH)) u_anc_ram (
    .clk_i  (clk_i),
    .we_i   (tab_we),
    .waddr_i(tab_addr(tab_wlvl, u_q)),
    .wdata_i(tab_wanc),
    .raddr_i(tab_addr(tab_rlvl, tab_rnode)),
    .rdata_o(anc_raw)
  );

  tplme_ram #(.WIDTH(WEIGHT_W), .DEPTH(TAB_DEPTH)) u_max_ram (
    .clk_i  (clk_i),
    .we_i   (tab_we),
    .waddr_i(tab_addr(tab_wlvl, u_q)),
    .wdata_i(tab_wmax),
    .raddr_i(tab_addr(tab_rlvl, tab_rnode)),
    .rdata_o(max_raw)
  );

  assign best_ext = RESULT_W'(best_q);
  assign res_new  = it_q ? RESULT_W'(cost_q) :
                    ((sum_q >= best_ext) ? (sum_q - best_ext) : '0);

  always_ff @(posedge clk_i) begin
    dzero_q <= (dep_rnode == '0);
    tzero_q <= (tab_rnode == '0);
    case (cmd_i.op)
      OP_ACCEPT: begin
        u_q    <= node_of(node_a_i);
        v_q    <= node_of(node_b_i);
        w_q    <= weight_i;
        it_q   <= in_tree_i;
        sum_q  <= RESULT_W'(cost_q) + RESULT_W'(weight_i);
        best_q <= '0;
      end
      OP_LD_DEP: begin
        d_q   <= d_new;
        anc_q <= v_q;
        mx_q  <= w_q;
        lvl_q <= LVC_W'(1);
      end
      OP_LD_WR: begin
        anc_q <= anc_new;
        mx_q  <= max_new;
        lvl_q <= lvl_q + LVC_W'(1);
      end
      OP_Q_DB: da_q <= dep_rd;
      OP_Q_DC: begin
        lvl_q <= '0;
        if (da_q < dep_rd) begin
          u_q     <= v_q;
          v_q     <= u_q;
          delta_q <= LEVELS'(dep_rd - da_q);
        end else begin
          delta_q <= LEVELS'(da_q - dep_rd);
        end
      end
      OP_CL_SKIP: lvl_q <= lvl_q + LVC_W'(1);
      OP_CL_W: begin
        best_q <= wmax(best_q, max_rd);
        u_q    <= anc_rd;
        lvl_q  <= lvl_q + LVC_W'(1);
      end
      OP_LIFT_INIT: lvl_q <= LVC_W'(LEVELS - 1);
      OP_LB: begin
        au_q <= anc_rd;
        mu_q <= max_rd;
      end
      OP_LC: begin
        if (au_q != anc_rd) begin
          best_q <= wmax(best_q, wmax(mu_q, max_rd));
          u_q    <= au_q;
          v_q    <= anc_rd;
        end
        if (lvl_q != '0) begin
          lvl_q <= lvl_dec;
        end
      end
      OP_FB: mu_q <= max_rd;
      OP_FC: best_q <= wmax(best_q, wmax(mu_q, max_rd));
      OP_FIN: begin
        pm_q  <= best_q;
        res_q <= res_new;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cost_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cost_q <= cfg_wdata_i;
      end
      if (cmd_i.op == OP_FIN) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o        = out_valid_q;
  assign path_max_o         = pm_q;
  assign replacement_cost_o = res_q;

  assign status_o.in_func   = func_i;
  assign status_o.in_a_zero = (node_of(node_a_i) == '0);
  assign status_o.in_self   = (node_a_i == node_b_i);
  assign status_o.lvl_last  = (lvl_q == LVC_W'(LEVELS - 1));
  assign status_o.lvl_zero  = (lvl_q == '0);
  assign status_o.cl_done   = (lvl_q == LVC_W'(LEVELS));
  assign status_o.delta_bit = delta_q[lvl_idx];
  assign status_o.uv_eq     = (u_q == v_q);
  assign status_o.out_free  = !out_valid_q || out_ready_i;

endmodule

@@ hw/rtl/tree_path_max_lifting_engine_unit.sv @@
// Top level of the tree path-maximum engine: controller and datapath joined.
`timescale 1ns / 1ps
// Load and query steps are serialised by the single read port of the lifting tables.
// Throughput: one request at a time; a self-loop query skips straight to the result state.
// Reset: asynchronous, active low; clears the controller, result valid and tree cost.
// Table contents are not cleared; only entries written by loads should be read, which the block does not enforce.

module tree_path_max_lifting_engine_unit
  import tplme_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [COST_W-1:0]    cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 func_i,
  input  logic [IN_NODE_W-1:0] node_a_i,
  input  logic [IN_NODE_W-1:0] node_b_i,
  input  logic [WEIGHT_W-1:0]  weight_i,
  input  logic                 in_tree_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [WEIGHT_W-1:0]  path_max_o,
  output logic [RESULT_W-1:0]  replacement_cost_o
);

  // The controller walks each request through its phases: for a load, the
  // parent depth read and then one read-modify-write per lifting level; for a
  // query, the two depth reads, the climb of the deeper node, the joint
  // descent from the top level and the final parent-edge reads.
  dp_cmd_t    cmd;
  dp_status_t status;

  tplme_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  // The datapath owns the three tables, the working registers and the result
  // register, so a finished result waits there while the next request starts.
  tplme_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .func_i            (func_i),
    .node_a_i          (node_a_i),
    .node_b_i          (node_b_i),
    .weight_i          (weight_i),
    .in_tree_i         (in_tree_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .path_max_o        (path_max_o),
    .replacement_cost_o(replacement_cost_o)
  );

endmodule
